// ===== src/mbw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbw_pkg
// Shared types, codes and helper functions of the maze backtracker walk.
// ----------------------------------------------------------------------------
package mbw_pkg;

  // field widths fixed by the stream format
  localparam int CMD_W      = 2;
  localparam int POS_W      = 6;
  localparam int RAND_W     = 16;
  localparam int EV_W       = 3;
  localparam int DEPTH_W    = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  typedef logic [4:0] cell_t;
  typedef logic [1:0] dir_t;

  // commands
  localparam logic [CMD_W-1:0] CMD_START = 2'd0;
  localparam logic [CMD_W-1:0] CMD_STEP  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  // result events
  localparam logic [EV_W-1:0] EV_READ     = 3'd0;
  localparam logic [EV_W-1:0] EV_ADVANCED = 3'd1;
  localparam logic [EV_W-1:0] EV_BACK     = 3'd2;
  localparam logic [EV_W-1:0] EV_FINISHED = 3'd3;
  localparam logic [EV_W-1:0] EV_STARTED  = 3'd4;

  // directions
  localparam dir_t DIR_N = 2'd0;
  localparam dir_t DIR_W = 2'd1;
  localparam dir_t DIR_S = 2'd2;
  localparam dir_t DIR_E = 2'd3;

  // cell bits
  localparam cell_t OPEN_N    = 5'h01;
  localparam cell_t OPEN_W    = 5'h02;
  localparam cell_t OPEN_S    = 5'h04;
  localparam cell_t OPEN_E    = 5'h08;
  localparam cell_t CELL_SEEN = 5'h10;
  localparam int    SEEN_BIT  = 4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;
  localparam logic [CFG_DATA_W-1:0] GRID_RESET     = 7'd64;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ_CAP,
    ST_PROBE,
    ST_PROBE_END,
    ST_PICK,
    ST_WR_TOP,
    ST_WR_NBR,
    ST_POP_STK,
    ST_POP_CELL,
    ST_POP_CAP,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic none;
    dir_t dir;
  } pick_t;

  function automatic cell_t side_bit(input dir_t d);
    case (d)
      DIR_N:   side_bit = OPEN_N;
      DIR_W:   side_bit = OPEN_W;
      DIR_S:   side_bit = OPEN_S;
      default: side_bit = OPEN_E;
    endcase
  endfunction

  // side seen from the cell on the far side of the wall
  function automatic dir_t back_dir(input dir_t d);
    case (d)
      DIR_N:   back_dir = DIR_S;
      DIR_W:   back_dir = DIR_E;
      DIR_S:   back_dir = DIR_N;
      default: back_dir = DIR_W;
    endcase
  endfunction

  // v mod 3: base-4 digit sums, since 4 and 16 are 1 mod 3
  function automatic logic [1:0] mod3_16(input logic [RAND_W-1:0] v);
    logic [4:0] s;
    logic [2:0] s2;
    logic [2:0] s3;
    s = '0;
    for (int i = 0; i < RAND_W / 2; i++) begin
      s = s + 5'(v[2*i +: 2]);
    end
    s2 = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
    s3 = 3'(s2[1:0]) + 3'(s2[2]);
    if (s3 >= 3'd3) begin
      s3 = s3 - 3'd3;
    end
    mod3_16 = s3[1:0];
  endfunction

endpackage

// ===== src/mbw_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbw_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mbw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== src/mbw_pick.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbw_pick
// Chooses one free neighbor: the (rand mod count)-th set bit of the mask.
// ----------------------------------------------------------------------------
module mbw_pick (
  input  logic [3:0]                 mask,
  input  logic [mbw_pkg::RAND_W-1:0] rnd,
  output mbw_pkg::pick_t             pick_out
);
  import mbw_pkg::*;

  logic [2:0] cnt;
  logic [1:0] sel;
  logic [2:0] k;

  always_comb begin
    cnt = '0;
    for (int i = 0; i < 4; i++) begin
      cnt = cnt + 3'(mask[i]);
    end
    case (cnt)
      3'd2:    sel = {1'b0, rnd[0]};
      3'd3:    sel = mod3_16(rnd);
      3'd4:    sel = rnd[1:0];
      default: sel = '0;
    endcase
    pick_out.none = (mask == '0);
    pick_out.dir  = DIR_N;
    k = '0;
    for (int i = 0; i < 4; i++) begin
      if (mask[i]) begin
        if (k == 3'(sel)) begin
          pick_out.dir = 2'(i);
        end
        k = k + 3'd1;
      end
    end
  end

endmodule

// ===== src/maze_backtracker_walk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// maze_backtracker_walk
// Randomized depth-first maze carving over a cell RAM and a position stack.
// ----------------------------------------------------------------------------
// The block carves a maze one command at a time. Cell state (four open sides
// plus a visited flag) lives in a MAX_WIDTH x MAX_HEIGHT RAM addressed as
// x + y*MAX_WIDTH; the walk path lives in a stack RAM of the same depth, with
// the top position and depth held in registers. Each input transaction gives
// one result transaction, except command 3, which is taken and dropped.
// A start sweeps the whole cell RAM one entry per cycle. A step is paced by
// the single read port of the cell RAM: four neighbor reads plus the top
// cell, then two writes on the single write port. A backtrack that leaves
// entries on the stack reads the new top from the stack RAM and then its
// cell. After reset the same sweep runs before in_tready first rises;
// configuration writes are taken at any time. The result sits in an output
// register, so the next item is accepted while it waits.
module maze_backtracker_walk #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input stream
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [31:0]                  in_tdata,   // pos_x[5:0], pos_y[11:6], rand_value[27:12]
  input  logic [1:0]                   in_tuser,   // cmd[1:0]
  // result stream
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [31:0]                  out_tdata,  // cell_bits[4:0], moved_dir[6:5],
                                                   // top_x[12:7], top_y[18:13], depth_now[31:19]
  output logic [2:0]                   out_tuser,  // event_res[2:0]
  // configuration
  input  logic                         cfg_we,
  input  logic [mbw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbw_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import mbw_pkg::*;

  localparam int CELL_COUNT = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW   = $clog2(CELL_COUNT);
  localparam int CXW  = $clog2(MAX_WIDTH);
  localparam int CYW  = $clog2(MAX_HEIGHT);
  localparam int SW   = CXW + CYW;
  localparam int CW   = $clog2(CELL_COUNT + 1);
  localparam int DW   = $clog2(((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT) + 1);
  localparam int LW   = (DW > CFG_DATA_W) ? DW : CFG_DATA_W;

  // input fields
  logic [CMD_W-1:0]  in_cmd;
  logic [POS_W-1:0]  in_px;
  logic [POS_W-1:0]  in_py;
  logic [RAND_W-1:0] in_rand;

  assign in_cmd  = in_tuser;
  assign in_px   = in_tdata[5:0];
  assign in_py   = in_tdata[11:6];
  assign in_rand = in_tdata[27:12];

  // registers
  state_t                state_r, state_nxt;
  logic [CFG_DATA_W-1:0] gw_r, gh_r;
  logic [AW-1:0]         clr_addr_r, clr_addr_nxt;
  logic                  clr_start_r, clr_start_nxt;
  logic [CXW-1:0]        st_x_r, st_x_nxt;
  logic [CYW-1:0]        st_y_r, st_y_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [CXW-1:0]        top_x_r, top_x_nxt;
  logic [CYW-1:0]        top_y_r, top_y_nxt;
  logic [2:0]            idx_r, idx_nxt;
  logic                  pend_r, pend_nxt;
  logic [2:0]            pend_idx_r, pend_idx_nxt;
  logic [3:0]            mask_r, mask_nxt;
  cell_t                 nbr_r [4];
  cell_t                 nbr_nxt [4];
  cell_t                 topc_r, topc_nxt;
  logic [RAND_W-1:0]     rnd_r, rnd_nxt;
  dir_t                  dir_r, dir_nxt;
  logic [EV_W-1:0]       ev_r, ev_nxt;
  cell_t                 bits_r, bits_nxt;
  logic                  rd_ok_r, rd_ok_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [EV_W-1:0]       out_ev_r, out_ev_nxt;
  cell_t                 out_bits_r, out_bits_nxt;
  dir_t                  out_dir_r, out_dir_nxt;
  logic [POS_W-1:0]      out_tx_r, out_tx_nxt;
  logic [POS_W-1:0]      out_ty_r, out_ty_nxt;
  logic [DEPTH_W-1:0]    out_depth_r, out_depth_nxt;

  // memory ports
  logic          cell_we;
  logic [AW-1:0] cell_waddr;
  cell_t         cell_wdata;
  logic [AW-1:0] cell_raddr;
  cell_t         cell_rdata;
  logic          stk_we;
  logic [AW-1:0] stk_waddr;
  logic [SW-1:0] stk_wdata;
  logic [AW-1:0] stk_raddr;
  logic [SW-1:0] stk_rdata;

  pick_t pick;

  function automatic logic [AW-1:0] cell_addr(input logic [CXW-1:0] x,
                                               input logic [CYW-1:0] y);
    cell_addr = AW'(x) + AW'(AW'(y) * AW'(MAX_WIDTH));
  endfunction

  function automatic logic [CXW-1:0] step_x(input logic [CXW-1:0] x, input dir_t d);
    case (d)
      DIR_W:   step_x = x - CXW'(1);
      DIR_E:   step_x = x + CXW'(1);
      default: step_x = x;
    endcase
  endfunction

  function automatic logic [CYW-1:0] step_y(input logic [CYW-1:0] y, input dir_t d);
    case (d)
      DIR_N:   step_y = y - CYW'(1);
      DIR_S:   step_y = y + CYW'(1);
      default: step_y = y;
    endcase
  endfunction

  // grid limits: zero counts as one, above the maximum counts as the maximum
  logic [CXW-1:0] last_x;
  logic [CYW-1:0] last_y;

  always_comb begin
    if (gw_r == '0) begin
      last_x = '0;
    end else if (LW'(gw_r) > LW'(MAX_WIDTH)) begin
      last_x = CXW'(MAX_WIDTH - 1);
    end else begin
      last_x = CXW'(LW'(gw_r) - LW'(1));
    end
    if (gh_r == '0) begin
      last_y = '0;
    end else if (LW'(gh_r) > LW'(MAX_HEIGHT)) begin
      last_y = CYW'(MAX_HEIGHT - 1);
    end else begin
      last_y = CYW'(LW'(gh_r) - LW'(1));
    end
  end

  // in-bounds neighbors of the stack top; a full stack sees none
  logic [3:0]    nb_ok;
  logic [AW-1:0] top_addr;
  logic          stack_full;

  assign stack_full = (count_r == CW'(CELL_COUNT));
  assign top_addr   = cell_addr(top_x_r, top_y_r);

  always_comb begin
    nb_ok[DIR_N] = (top_y_r != '0);
    nb_ok[DIR_W] = (top_x_r != '0);
    nb_ok[DIR_S] = (top_y_r < last_y);
    nb_ok[DIR_E] = (top_x_r < last_x);
    if (stack_full) begin
      nb_ok = '0;
    end
  end

  // neighbor in the chosen direction
  logic [CXW-1:0] mv_x;
  logic [CYW-1:0] mv_y;
  cell_t          mv_bits;

  assign mv_x    = step_x(top_x_r, dir_r);
  assign mv_y    = step_y(top_y_r, dir_r);
  assign mv_bits = nbr_r[dir_r] | CELL_SEEN | side_bit(back_dir(dir_r));

  assign in_tready = (state_r == ST_IDLE);

  mbw_pick u_pick (
    .mask     (mask_r),
    .rnd      (rnd_r),
    .pick_out (pick)
  );

  mbw_ram #(.WIDTH($bits(cell_t)), .DEPTH(CELL_COUNT)) u_cell_ram (
    .clk     (clk),
    .wr_en   (cell_we),
    .wr_addr (cell_waddr),
    .wr_data (cell_wdata),
    .rd_addr (cell_raddr),
    .rd_data (cell_rdata)
  );

  mbw_ram #(.WIDTH(SW), .DEPTH(CELL_COUNT)) u_stack_ram (
    .clk     (clk),
    .wr_en   (stk_we),
    .wr_addr (stk_waddr),
    .wr_data (stk_wdata),
    .rd_addr (stk_raddr),
    .rd_data (stk_rdata)
  );

  always_comb begin
    logic [CXW-1:0] sx;
    logic [CYW-1:0] sy;
    logic [CXW-1:0] px_sat;
    logic [CYW-1:0] py_sat;

    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    clr_start_nxt = clr_start_r;
    st_x_nxt      = st_x_r;
    st_y_nxt      = st_y_r;
    count_nxt     = count_r;
    top_x_nxt     = top_x_r;
    top_y_nxt     = top_y_r;
    idx_nxt       = idx_r;
    pend_nxt      = 1'b0;
    pend_idx_nxt  = idx_r;
    mask_nxt      = mask_r;
    nbr_nxt       = nbr_r;
    topc_nxt      = topc_r;
    rnd_nxt       = rnd_r;
    dir_nxt       = dir_r;
    ev_nxt        = ev_r;
    bits_nxt      = bits_r;
    rd_ok_nxt     = rd_ok_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_ev_nxt    = out_ev_r;
    out_bits_nxt  = out_bits_r;
    out_dir_nxt   = out_dir_r;
    out_tx_nxt    = out_tx_r;
    out_ty_nxt    = out_ty_r;
    out_depth_nxt = out_depth_r;

    cell_we    = 1'b0;
    cell_waddr = '0;
    cell_wdata = '0;
    cell_raddr = top_addr;
    stk_we     = 1'b0;
    stk_waddr  = '0;
    stk_wdata  = '0;
    stk_raddr  = AW'(count_r - CW'(1));

    sx = stk_rdata[CXW-1:0];
    sy = stk_rdata[SW-1:CXW];
    px_sat = (LW'(in_px) > LW'(last_x)) ? last_x : CXW'(in_px);
    py_sat = (LW'(in_py) > LW'(last_y)) ? last_y : CYW'(in_py);

    // probe data returns in the cycle after its read
    if (pend_r) begin
      if (pend_idx_r == 3'd4) begin
        topc_nxt = cell_rdata;
      end else begin
        nbr_nxt[pend_idx_r[1:0]]  = cell_rdata;
        mask_nxt[pend_idx_r[1:0]] = nb_ok[pend_idx_r[1:0]] && !cell_rdata[SEEN_BIT];
      end
    end

    case (state_r)
      ST_CLEAR: begin
        cell_we    = 1'b1;
        cell_waddr = clr_addr_r;
        cell_wdata = (clr_start_r && clr_addr_r == cell_addr(st_x_r, st_y_r)) ?
                     CELL_SEEN : '0;
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(CELL_COUNT - 1)) begin
          clr_addr_nxt = '0;
          if (clr_start_r) begin
            stk_we    = 1'b1;
            stk_waddr = '0;
            stk_wdata = {st_y_r, st_x_r};
            count_nxt = CW'(1);
            top_x_nxt = st_x_r;
            top_y_nxt = st_y_r;
            ev_nxt    = EV_STARTED;
            bits_nxt  = CELL_SEEN;
            dir_nxt   = DIR_N;
            state_nxt = ST_EMIT;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          case (in_cmd)
            CMD_START: begin
              st_x_nxt      = px_sat;
              st_y_nxt      = py_sat;
              clr_start_nxt = 1'b1;
              clr_addr_nxt  = '0;
              state_nxt     = ST_CLEAR;
            end
            CMD_STEP: begin
              rnd_nxt = in_rand;
              dir_nxt = DIR_N;
              if (count_r == '0) begin
                ev_nxt    = EV_FINISHED;
                bits_nxt  = '0;
                state_nxt = ST_EMIT;
              end else begin
                idx_nxt   = '0;
                mask_nxt  = '0;
                state_nxt = ST_PROBE;
              end
            end
            CMD_READ: begin
              ev_nxt     = EV_READ;
              dir_nxt    = DIR_N;
              rd_ok_nxt  = (LW'(in_px) < LW'(MAX_WIDTH)) && (LW'(in_py) < LW'(MAX_HEIGHT));
              cell_raddr = cell_addr(CXW'(in_px), CYW'(in_py));
              state_nxt  = ST_READ_CAP;
            end
            default: begin
              // unused command: taken, no result
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_READ_CAP: begin
        bits_nxt  = rd_ok_r ? cell_rdata : '0;
        state_nxt = ST_EMIT;
      end
      ST_PROBE: begin
        if (idx_r == 3'd4) begin
          cell_raddr = top_addr;
          state_nxt  = ST_PROBE_END;
        end else if (nb_ok[idx_r[1:0]]) begin
          cell_raddr = cell_addr(step_x(top_x_r, idx_r[1:0]), step_y(top_y_r, idx_r[1:0]));
        end
        pend_nxt     = 1'b1;
        pend_idx_nxt = idx_r;
        idx_nxt      = idx_r + 3'd1;
      end
      ST_PROBE_END: begin
        state_nxt = ST_PICK;
      end
      ST_PICK: begin
        if (pick.none) begin
          count_nxt = count_r - CW'(1);
          ev_nxt    = EV_BACK;
          dir_nxt   = DIR_N;
          if (count_r == CW'(1)) begin
            bits_nxt  = '0;
            state_nxt = ST_EMIT;
          end else begin
            state_nxt = ST_POP_STK;
          end
        end else begin
          dir_nxt   = pick.dir;
          state_nxt = ST_WR_TOP;
        end
      end
      ST_WR_TOP: begin
        cell_we    = 1'b1;
        cell_waddr = top_addr;
        cell_wdata = topc_r | side_bit(dir_r);
        stk_we     = 1'b1;
        stk_waddr  = AW'(count_r);
        stk_wdata  = {mv_y, mv_x};
        state_nxt  = ST_WR_NBR;
      end
      ST_WR_NBR: begin
        cell_we    = 1'b1;
        cell_waddr = cell_addr(mv_x, mv_y);
        cell_wdata = mv_bits;
        bits_nxt   = mv_bits;
        top_x_nxt  = mv_x;
        top_y_nxt  = mv_y;
        count_nxt  = count_r + CW'(1);
        ev_nxt     = EV_ADVANCED;
        state_nxt  = ST_EMIT;
      end
      ST_POP_STK: begin
        // stack read of the new top is on the default address
        state_nxt = ST_POP_CELL;
      end
      ST_POP_CELL: begin
        top_x_nxt  = sx;
        top_y_nxt  = sy;
        cell_raddr = cell_addr(sx, sy);
        state_nxt  = ST_POP_CAP;
      end
      ST_POP_CAP: begin
        bits_nxt  = cell_rdata;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_ev_nxt    = ev_r;
          out_bits_nxt  = bits_r;
          out_dir_nxt   = dir_r;
          out_tx_nxt    = (count_r == '0) ? '0 : POS_W'(top_x_r);
          out_ty_nxt    = (count_r == '0) ? '0 : POS_W'(top_y_r);
          out_depth_nxt = DEPTH_W'(count_r);
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      clr_start_r <= 1'b0;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      gw_r        <= GRID_RESET;
      gh_r        <= GRID_RESET;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      clr_start_r <= clr_start_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && cfg_index == REG_GRID_WIDTH) begin
        gw_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == REG_GRID_HEIGHT) begin
        gh_r <= cfg_wdata;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    st_x_r      <= st_x_nxt;
    st_y_r      <= st_y_nxt;
    top_x_r     <= top_x_nxt;
    top_y_r     <= top_y_nxt;
    idx_r       <= idx_nxt;
    pend_idx_r  <= pend_idx_nxt;
    mask_r      <= mask_nxt;
    nbr_r       <= nbr_nxt;
    topc_r      <= topc_nxt;
    rnd_r       <= rnd_nxt;
    dir_r       <= dir_nxt;
    ev_r        <= ev_nxt;
    bits_r      <= bits_nxt;
    rd_ok_r     <= rd_ok_nxt;
    out_ev_r    <= out_ev_nxt;
    out_bits_r  <= out_bits_nxt;
    out_dir_r   <= out_dir_nxt;
    out_tx_r    <= out_tx_nxt;
    out_ty_r    <= out_ty_nxt;
    out_depth_r <= out_depth_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_ev_r;
  assign out_tdata  = {out_depth_r, out_ty_r, out_tx_r, out_dir_r, out_bits_r};

  // stack depth never passes the store size
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CELL_COUNT))
    else $error("stack depth beyond cell count");

  // a step on an empty stack goes straight to the result
  a_empty_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_cmd == CMD_STEP && count_r == '0 |=> state_r == ST_EMIT)
    else $error("empty-stack step did not report at once");

  // the carved direction is one of the free neighbors
  a_carve_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WR_TOP |-> mask_r[dir_r])
    else $error("carving toward a visited or outside cell");

  // an advance pushes exactly one position
  a_push_one: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WR_NBR |=> count_r == $past(count_r) + CW'(1))
    else $error("advance did not push one position");

  // a pending result is not overwritten
  a_emit_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT && out_valid_r && !out_tready |=> state_r == ST_EMIT && out_valid_r)
    else $error("result register overwritten while full");

endmodule
